// ===== hdl/ccfw_pkg.sv =====
// shared types and constants for the character-counting flow window
`default_nettype none

package ccfw_pkg;

  // event codes carried on req_type
  typedef enum logic [2:0] {
    REQ_OFFER  = 3'd0,
    REQ_OK     = 3'd1,
    REQ_ERROR  = 3'd2,
    REQ_OTHER  = 3'd3,
    REQ_TICK   = 3'd4,
    REQ_CANCEL = 3'd5
  } req_type_e;

  // job status codes
  typedef enum logic [2:0] {
    ST_RUNNING  = 3'd0,
    ST_DONE     = 3'd1,
    ST_TOO_LONG = 3'd2,
    ST_ERROR    = 3'd3,
    ST_TIMEOUT  = 3'd4,
    ST_CANCEL   = 3'd5
  } job_status_e;

  // sequencer states
  typedef enum logic {
    FSM_IDLE,
    FSM_POP
  } fsm_e;

  // configuration register indexes
  localparam logic CfgWindow  = 1'b0;
  localparam logic CfgTimeout = 1'b1;

  localparam logic [7:0]  WindowReset  = 8'd127;
  localparam logic [15:0] TimeoutReset = 16'd5000;
  localparam int          FifoDepthDefault = 64;

endpackage

`default_nettype wire

// ===== hdl/char_count_flow_window_unit.sv =====
// top level: character-counting flow control with a length fifo in block memory
`default_nettype none

// Host-side flow control window. Each accepted item is one event (line offer, ok, error,
// other line, tick or cancel) and gives exactly one result item from an output register.
// A new item is taken in the same cycle as the previous result leaves, but not while that
// result is held by a stall. Every event is handled in the idle state except an ok that
// retires a pending line: that one also passes through the pop state, as the oldest line
// length is read from the synchronous length memory before the counters are updated. The
// length memory needs no clearing pass after reset; entries are only read once written.
// Configuration writes are always taken (ready tied high) and must only be made while the
// block is idle.
module char_count_flow_window_unit #(
  parameter int FIFO_DEPTH = ccfw_pkg::FifoDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  // event input
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [9:0]  line_length_i,
  input  wire logic        is_last_line_i,
  // result output
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             line_accepted_o,
  output logic [2:0]       job_status_o,
  output logic [7:0]       pending_bytes_o,
  output logic [7:0]       pending_lines_o,
  output logic [31:0]      acked_bytes_o
);

  import ccfw_pkg::*;

  localparam int IdxW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CntW = $clog2(FIFO_DEPTH + 1);

  // configuration
  logic [7:0]  window_q;
  logic [15:0] timeout_q;

  // flow state
  fsm_e            state_q, state_d;
  logic [IdxW-1:0] head_q, head_d;
  logic [IdxW-1:0] tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;
  logic [7:0]      outstanding_q, outstanding_d;
  logic [31:0]     acked_q, acked_d;
  logic [15:0]     idle_q, idle_d;
  job_status_e     outcome_q, outcome_d;
  logic            last_sent_q, last_sent_d;

  // result register
  logic        res_valid_q, res_valid_d;
  logic        res_accepted_q, res_accepted_d;
  job_status_e res_status_q;
  logic [7:0]  res_bytes_q;
  logic [7:0]  res_lines_q;
  logic [31:0] res_acked_q;

  // length memory
  logic [7:0]  mem_q [FIFO_DEPTH];
  logic [7:0]  rd_data_q;
  logic        mem_we;

  logic        in_fire;
  logic        pop_start;
  logic        load_res;

  logic [10:0] offer_sum;
  logic [16:0] tick_next;
  logic [32:0] acked_sum;
  logic [IdxW-1:0] head_inc;
  logic [IdxW-1:0] tail_inc;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q  <= WindowReset;
      timeout_q <= TimeoutReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgWindow:  window_q  <= cfg_data_i[7:0];
        CfgTimeout: timeout_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // handshake outputs
  always_comb begin
    in_stall_o = (state_q != FSM_IDLE) || (res_valid_q && out_stall_i);
  end

  assign in_fire = in_valid_i && !in_stall_o;

  assign offer_sum = {3'b000, outstanding_q} + {1'b0, line_length_i};
  assign tick_next = {1'b0, idle_q} + 17'd1;
  assign acked_sum = {1'b0, acked_q} + {25'd0, rd_data_q};
  assign head_inc  = (head_q == IdxW'(FIFO_DEPTH - 1)) ? '0 : head_q + IdxW'(1);
  assign tail_inc  = (tail_q == IdxW'(FIFO_DEPTH - 1)) ? '0 : tail_q + IdxW'(1);

  // event processing
  always_comb begin
    head_d         = head_q;
    tail_d         = tail_q;
    count_d        = count_q;
    outstanding_d  = outstanding_q;
    acked_d        = acked_q;
    idle_d         = idle_q;
    outcome_d      = outcome_q;
    last_sent_d    = last_sent_q;
    res_accepted_d = 1'b0;
    mem_we         = 1'b0;
    pop_start      = 1'b0;
    load_res       = 1'b0;

    if (state_q == FSM_IDLE) begin
      if (in_fire) begin
        if (outcome_q == ST_RUNNING) begin
          unique case (req_type_e'(req_type_i))
            REQ_OFFER: begin
              if (!last_sent_q) begin
                priority if (line_length_i > {2'b00, window_q}) begin
                  outcome_d = ST_TOO_LONG;
                end else if (count_q == CntW'(FIFO_DEPTH)) begin
                  // fifo full, line waits
                end else if (offer_sum > {3'b000, window_q}) begin
                  // window full, line waits
                end else begin
                  mem_we         = 1'b1;
                  tail_d         = tail_inc;
                  count_d        = count_q + CntW'(1);
                  outstanding_d  = offer_sum[7:0];
                  last_sent_d    = last_sent_q | is_last_line_i;
                  res_accepted_d = 1'b1;
                end
              end
            end
            REQ_OK: begin
              idle_d    = '0;
              pop_start = (count_q != '0);
            end
            REQ_ERROR: begin
              idle_d    = '0;
              outcome_d = ST_ERROR;
            end
            REQ_OTHER: begin
              idle_d = '0;
            end
            REQ_TICK: begin
              if (tick_next > {1'b0, timeout_q}) begin
                outcome_d = ST_TIMEOUT;
              end else begin
                idle_d = tick_next[15:0];
              end
            end
            REQ_CANCEL: begin
              outcome_d = ST_CANCEL;
            end
            default: ;
          endcase
        end
        load_res = !pop_start;
      end
    end else begin
      // oldest length is now in rd_data_q
      head_d        = head_inc;
      count_d       = count_q - CntW'(1);
      outstanding_d = (outstanding_q >= rd_data_q) ? outstanding_q - rd_data_q : '0;
      acked_d       = acked_sum[32] ? '1 : acked_sum[31:0];
      if (last_sent_q && (count_q == CntW'(1))) begin
        outcome_d = ST_DONE;
      end
      load_res = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: if (in_fire && pop_start) state_d = FSM_POP;
      FSM_POP:  state_d = FSM_IDLE;
      default:  state_d = FSM_IDLE;
    endcase
  end

  always_comb begin
    res_valid_d = res_valid_q && out_stall_i;
    if (load_res) begin
      res_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= FSM_IDLE;
      head_q        <= '0;
      tail_q        <= '0;
      count_q       <= '0;
      outstanding_q <= '0;
      acked_q       <= '0;
      idle_q        <= '0;
      outcome_q     <= ST_RUNNING;
      last_sent_q   <= 1'b0;
      res_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      head_q        <= head_d;
      tail_q        <= tail_d;
      count_q       <= count_d;
      outstanding_q <= outstanding_d;
      acked_q       <= acked_d;
      idle_q        <= idle_d;
      outcome_q     <= outcome_d;
      last_sent_q   <= last_sent_d;
      res_valid_q   <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_res) begin
      res_accepted_q <= res_accepted_d;
      res_status_q   <= outcome_d;
      res_bytes_q    <= outstanding_d;
      res_lines_q    <= 8'(count_d);
      res_acked_q    <= acked_d;
    end
  end

  // length memory: accepted lengths never exceed the window, so eight bits hold them
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[tail_q] <= line_length_i[7:0];
    end
    rd_data_q <= mem_q[head_q];
  end

  assign out_valid_o     = res_valid_q;
  assign line_accepted_o = res_accepted_q;
  assign job_status_o    = res_status_q;
  assign pending_bytes_o = res_bytes_q;
  assign pending_lines_o = res_lines_q;
  assign acked_bytes_o   = res_acked_q;

  // a pop only starts with a line pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_POP) |-> (count_q != '0))
    else $error("pop started with empty fifo");

  // the result slot is free while a pop is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_POP) |-> !res_valid_q)
    else $error("result register busy during pop");

  // no bytes are pending while no lines are pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (outstanding_q == '0))
    else $error("bytes pending with no lines pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(FIFO_DEPTH))
    else $error("fifo count beyond depth");

  // an accepted line never finishes the job in the same item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_accepted_q) |-> (res_status_q == ST_RUNNING))
    else $error("accepted line with finished job");

endmodule

`default_nettype wire
